FILE: design/sps_pkg.sv
// shared types, register codes, mode codes and table helpers for the pose setpoint generator
`default_nettype none

package sps_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP = 3'd1;
  localparam logic [2:0] REG_GOAL_X     = 3'd2;
  localparam logic [2:0] REG_GOAL_Y     = 3'd3;
  localparam logic [2:0] REG_GOAL_Z     = 3'd4;
  localparam logic [2:0] REG_GOAL_ROLL  = 3'd5;
  localparam logic [2:0] REG_GOAL_PITCH = 3'd6;
  localparam logic [2:0] REG_GOAL_YAW   = 3'd7;

  // pattern select codes
  localparam logic [3:0] MODE_HOME    = 4'd0;
  localparam logic [3:0] MODE_X_WAVE  = 4'd1;
  localparam logic [3:0] MODE_Y_WAVE  = 4'd2;
  localparam logic [3:0] MODE_Z_WAVE  = 4'd3;
  localparam logic [3:0] MODE_ROLL    = 4'd4;
  localparam logic [3:0] MODE_PITCH   = 4'd5;
  localparam logic [3:0] MODE_YAW     = 4'd6;
  localparam logic [3:0] MODE_CIRCLE  = 4'd7;
  localparam logic [3:0] MODE_CONE    = 4'd8;
  localparam logic [3:0] MODE_GOAL    = 4'd9;

  // fixed point constants, lsb 2^-16
  localparam logic [14:0] K_003  = 15'd1966;
  localparam logic [14:0] K_0025 = 15'd1638;
  localparam logic [14:0] K_025  = 15'd16384;
  localparam logic signed [17:0] K_0175 = 18'sd11469;
  localparam logic signed [17:0] K_015  = 18'sd9830;
  localparam logic signed [17:0] K_017  = 18'sd11141;

  // reset values of the configuration registers
  localparam logic [23:0] PHASE_STEP_RST = 24'd335544;
  localparam logic signed [17:0] GOAL_Z_RST = 18'sd9830;

  // pi/2 in q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // one six-axis pose
  typedef struct packed {
    logic signed [17:0] yaw;
    logic signed [17:0] pitch;
    logic signed [17:0] roll;
    logic signed [17:0] z;
    logic signed [17:0] y;
    logic signed [17:0] x;
  } pose_t;

  // unsigned quotient by shift and subtract, elaboration only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine entry k in q16, taylor series in q30, elaboration only
  function automatic logic [16:0] sine_entry(input int k, input int tbits);
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    int n;
    x    = (HALF_PI_Q30 * longint'(k)) >> tbits;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv(term, 64'((2 * n) * (2 * n + 1)));
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 8192) >>> 14;
    if (v > 65536) begin
      v = 65536;
    end
    return v[16:0];
  endfunction

  // a * v / 65536 rounded half up
  function automatic logic signed [17:0] scale(input logic [14:0] a,
                                              input logic signed [17:0] v);
    logic signed [34:0] prod;
    prod = $signed({1'b0, a}) * v + 35'sd32768;
    return prod[33:16];
  endfunction

endpackage

`default_nettype wire

FILE: design/sps_sine.sv
// quarter-wave table lookup giving sine and cosine of one phase
`default_nettype none

module sps_sine #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic [PHASE_BITS-1:0] phase,
  output logic signed [17:0]    sin_val,
  output logic signed [17:0]    cos_val
);
  import sps_pkg::*;

  localparam int TBL_N  = 1 << SINE_TABLE_BITS;
  localparam int IDX_W  = SINE_TABLE_BITS + 1;
  localparam int WIDE_W = PHASE_BITS - 2 + SINE_TABLE_BITS;

  logic [16:0]                qtab [TBL_N+1];
  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [WIDE_W-1:0]          wide;
  logic [SINE_TABLE_BITS-1:0] rem_idx;
  logic [IDX_W-1:0]           idx_fwd;
  logic [IDX_W-1:0]           idx_rev;
  logic [IDX_W-1:0]           idx_s;
  logic [IDX_W-1:0]           idx_c;
  logic [16:0]                mag_s;
  logic [16:0]                mag_c;

  // constant table, built at elaboration
  for (genvar k = 0; k <= TBL_N; k++) begin : g_tab
    localparam logic [16:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
    assign qtab[k] = ENTRY;
  end

  // quadrant and position within it; cosine sits one quadrant ahead
  always_comb begin
    quad_s  = phase[PHASE_BITS-1 -: 2];
    quad_c  = quad_s + 2'd1;
    wide    = {phase[PHASE_BITS-3:0], {SINE_TABLE_BITS{1'b0}}};
    rem_idx = wide[WIDE_W-1 -: SINE_TABLE_BITS];
    idx_fwd = {1'b0, rem_idx};
    idx_rev = IDX_W'(TBL_N) - idx_fwd;
    idx_s   = quad_s[0] ? idx_rev : idx_fwd;
    idx_c   = quad_c[0] ? idx_rev : idx_fwd;
    mag_s   = qtab[idx_s];
    mag_c   = qtab[idx_c];
    sin_val = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    cos_val = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

endmodule

`default_nettype wire

FILE: design/sps_pose.sv
// pattern select and scaling of sine and cosine into one pose
`default_nettype none

module sps_pose (
  input  logic [3:0]         mode,
  input  logic signed [17:0] sin_val,
  input  logic signed [17:0] cos_val,
  input  sps_pkg::pose_t     goal,
  output sps_pkg::pose_t     pose
);
  import sps_pkg::*;

  logic signed [17:0] c_003;
  logic signed [17:0] s_003;
  logic signed [17:0] c_0025;
  logic signed [17:0] c_025;
  logic signed [17:0] s_025;

  // constant scaling of the two waves
  always_comb begin
    c_003  = scale(K_003, cos_val);
    s_003  = scale(K_003, sin_val);
    c_0025 = scale(K_0025, cos_val);
    c_025  = scale(K_025, cos_val);
    s_025  = scale(K_025, sin_val);
  end

  // start from home, then overwrite the axes that the pattern drives
  always_comb begin
    pose       = '0;
    pose.z     = K_015;
    case (mode)
      MODE_X_WAVE: pose.x = -c_003;
      MODE_Y_WAVE: pose.y = -c_003;
      MODE_Z_WAVE: pose.z = K_0175 - c_0025;
      MODE_ROLL: begin
        pose.z    = K_017;
        pose.roll = s_025;
      end
      MODE_PITCH: begin
        pose.z     = K_017;
        pose.pitch = s_025;
      end
      MODE_YAW: pose.yaw = s_025;
      MODE_CIRCLE: begin
        pose.x = c_003;
        pose.y = s_003;
      end
      MODE_CONE: begin
        pose.z     = K_017;
        pose.roll  = c_025;
        pose.pitch = s_025;
      end
      MODE_GOAL: pose = goal;
      default: pose.z = K_015;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/sinusoidal_pose_setpoint_generator.sv
// Six-axis sinusoidal pose setpoint generator, top level.
// Each transaction on the s_ side is one timer tick; s_tdata bit 0 is the
// restart flag, which clears the phase before the tick is worked out. Each
// tick gives exactly one pose transaction on the m_ side: x, y, z, roll,
// pitch, yaw, 18-bit two's complement with an lsb of 2^-16 m or rad.
// The pose uses the current phase, then the phase advances by phase_step.
// Registers are written through cfg_we / cfg_index / cfg_wdata, one per
// cycle: 0 mode, 1 phase_step, 2..7 the goal. The user must write them
// only while no tick is in flight; the block itself does not enforce this.
// A pose passes the phase register, the sine/cosine register and the
// output register in that order. One tick is taken per cycle as long as
// the output is taken or has room, and the three stages move with it.
// When the receiver stalls, the output register holds its pose and the two
// stages behind it fill up; s_tready falls only once all three are full.
// Synchronous reset clears the phase, the stage valids and the registers to
// their defaults (mode home, phase_step 335544, goal z 0.15 m).
`default_nettype none

module sinusoidal_pose_setpoint_generator #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata,
  // tick input
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [0] restart, [7:1] zero
  // pose output
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // x, y, z, roll, pitch, yaw (18 bits each), [111:108] zero
);
  import sps_pkg::*;

  logic [3:0]            mode;
  logic [23:0]           phase_step;
  pose_t                 goal;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_now;

  logic                  v1;
  logic [PHASE_BITS-1:0] ph1;
  logic                  v2;
  logic signed [17:0]    sin2;
  logic signed [17:0]    cos2;
  logic                  ov;
  pose_t                 pose_out;

  logic                  out_adv;
  logic                  room2;
  logic                  room1;
  logic                  take;
  logic signed [17:0]    sin_lut;
  logic signed [17:0]    cos_lut;
  pose_t                 pose_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_HOME;
      phase_step <= PHASE_STEP_RST;
      goal       <= '{yaw: 18'sd0, pitch: 18'sd0, roll: 18'sd0,
                      z: GOAL_Z_RST, y: 18'sd0, x: 18'sd0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:       mode       <= cfg_wdata[3:0];
        REG_PHASE_STEP: phase_step <= cfg_wdata;
        REG_GOAL_X:     goal.x     <= cfg_wdata[17:0];
        REG_GOAL_Y:     goal.y     <= cfg_wdata[17:0];
        REG_GOAL_Z:     goal.z     <= cfg_wdata[17:0];
        REG_GOAL_ROLL:  goal.roll  <= cfg_wdata[17:0];
        REG_GOAL_PITCH: goal.pitch <= cfg_wdata[17:0];
        REG_GOAL_YAW:   goal.yaw   <= cfg_wdata[17:0];
        default:        mode       <= mode;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    out_adv   = !ov || m_tready;
    room2     = !v2 || out_adv;
    room1     = !v1 || room2;
    s_tready  = room1;
    take      = s_tvalid && room1;
    phase_now = s_tdata[0] ? '0 : phase_acc;
  end

  // phase accumulator and phase stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      v1        <= 1'b0;
    end else begin
      if (take) begin
        phase_acc <= phase_now + PHASE_BITS'(phase_step);
      end
      if (room1) begin
        v1 <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ph1 <= phase_now;
    end
  end

  // sine and cosine lookup
  sps_sine #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .phase   (ph1),
    .sin_val (sin_lut),
    .cos_val (cos_lut)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (room2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && room2) begin
      sin2 <= sin_lut;
      cos2 <= cos_lut;
    end
  end

  // pattern and scaling
  sps_pose u_pose (
    .mode    (mode),
    .sin_val (sin2),
    .cos_val (cos2),
    .goal    (goal),
    .pose    (pose_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_adv) begin
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && out_adv) begin
      pose_out <= pose_next;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {4'b0000, pose_out};

endmodule

`default_nettype wire

FILE: tb/sv/tb_sinusoidal_pose_setpoint_generator.sv
// self-checking testbench for the six-axis sinusoidal pose setpoint generator
`timescale 1ns / 1ps

module tb_sinusoidal_pose_setpoint_generator;
  import sps_pkg::*;

  // dut ports, all inputs known from time zero
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;   // [0] restart, [7:1] zero
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;        // x, y, z, roll, pitch, yaw (18 bits each), [111:108] zero

  // one row of the directed sequence
  typedef struct packed {
    logic       cfg_en;
    logic [2:0] idx;
    logic [23:0] val;
    logic       restart;
    logic       typed;
    pose_t      want;
  } tick_row_t;

  localparam int NUM_ROWS     = 25;
  localparam int RANDOM_TICKS = 1650;

  // mirror of the block: registers, phase and sine table
  logic [3:0]         cfg_mode = MODE_HOME;
  logic [23:0]        cfg_step = PHASE_STEP_RST;
  logic signed [17:0] cfg_goal [6] = '{18'sd0, 18'sd0, GOAL_Z_RST, 18'sd0, 18'sd0, 18'sd0};
  logic [23:0]        phase_now = '0;
  int                 sine_lut [0:256];

  pose_t     pose_queue [$];
  tick_row_t rows [NUM_ROWS];
  int        error_count = 0;
  int        results_seen = 0;
  int        ticks_sent = 0;
  int        burst_left = 0;
  pose_t     got;
  pose_t     want;
  string     axis_name [6] = '{"x", "y", "z", "roll", "pitch", "yaw"};

  sinusoidal_pose_setpoint_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quarter-wave sine table in q16 from a truncating q30 taylor series
  initial begin
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    for (int k = 0; k <= 256; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >> 8;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 8192) / 16384;
      if (v > 65536) begin
        v = 65536;
      end
      sine_lut[k] = int'(v);
    end
  end

  function automatic pose_t mk_pose(int x, int y, int z, int roll, int pitch, int yaw);
    pose_t p;
    p.x     = 18'(x);
    p.y     = 18'(y);
    p.z     = 18'(z);
    p.roll  = 18'(roll);
    p.pitch = 18'(pitch);
    p.yaw   = 18'(yaw);
    return p;
  endfunction

  // sine of a phase in q16, quadrant by symmetry
  function automatic int sin_q16(logic [23:0] p);
    int r;
    int v;
    r = int'(p[21:14]);
    v = p[22] ? sine_lut[256 - r] : sine_lut[r];
    return p[23] ? -v : v;
  endfunction

  // a * v / 65536 rounded half up
  function automatic int mul_q16(int a, int v);
    longint p;
    p = longint'(a) * longint'(v) + 64'sd32768;
    return int'(p >>> 16);
  endfunction

  // pose for one tick, then advance the phase
  function automatic pose_t next_pose(logic restart);
    pose_t p;
    int s;
    int c;
    if (restart) begin
      phase_now = '0;
    end
    s = sin_q16(phase_now);
    c = sin_q16(phase_now + 24'h400000);
    p = mk_pose(0, 0, K_015, 0, 0, 0);
    case (cfg_mode)
      MODE_X_WAVE: p.x = 18'(-mul_q16(K_003, c));
      MODE_Y_WAVE: p.y = 18'(-mul_q16(K_003, c));
      MODE_Z_WAVE: p.z = 18'(K_0175 - mul_q16(K_0025, c));
      MODE_ROLL: begin
        p.z    = K_017;
        p.roll = 18'(mul_q16(K_025, s));
      end
      MODE_PITCH: begin
        p.z     = K_017;
        p.pitch = 18'(mul_q16(K_025, s));
      end
      MODE_YAW: p.yaw = 18'(mul_q16(K_025, s));
      MODE_CIRCLE: begin
        p.x = 18'(mul_q16(K_003, c));
        p.y = 18'(mul_q16(K_003, s));
      end
      MODE_CONE: begin
        p.z     = K_017;
        p.roll  = 18'(mul_q16(K_025, c));
        p.pitch = 18'(mul_q16(K_025, s));
      end
      MODE_GOAL: begin
        p.x     = cfg_goal[0];
        p.y     = cfg_goal[1];
        p.z     = cfg_goal[2];
        p.roll  = cfg_goal[3];
        p.pitch = cfg_goal[4];
        p.yaw   = cfg_goal[5];
      end
      default: ;
    endcase
    phase_now = phase_now + cfg_step;
    return p;
  endfunction

  // register write, mirrored at once; caller drops cfg_we after the batch
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE:       cfg_mode = val[3:0];
      REG_PHASE_STEP: cfg_step = val;
      default:        cfg_goal[idx - REG_GOAL_X] = val[17:0];
    endcase
    @(posedge clk);
  endtask

  // stop offering ticks and wait for every pose to come back
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pose_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // offer one tick, queue its pose on acceptance, then maybe pause
  task automatic send_tick(logic restart, logic typed, pose_t fixed);
    pose_t pred;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    pred = next_pose(restart);
    pose_queue.push_back(typed ? fixed : pred);
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: stall patterns in stretches, plus long hold-offs under load
  initial begin
    int style;
    int stretch;
    int next_hold_at;
    logic rdy;
    next_hold_at = 300;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      style   = $urandom_range(0, 3);
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        if (results_seen >= next_hold_at && s_tvalid) begin
          // hold off long enough for the pipeline to back up
          next_hold_at += 700;
          m_tready <= 1'b0;
          repeat (60) @(posedge clk);
        end
        case (style)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 1);
          2:       rdy = ($urandom_range(0, 7) != 0);
          default: rdy = ~m_tready;
        endcase
        m_tready <= rdy;
        @(posedge clk);
      end
    end
  end

  // compare each pose transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = pose_t'(m_tdata[107:0]);
      results_seen++;
      if (pose_queue.size() == 0) begin
        $display("%0t: unexpected pose transaction, expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = pose_queue.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got[i*18 +: 18] !== want[i*18 +: 18]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, axis_name[i],
                     $signed(want[i*18 +: 18]), $signed(got[i*18 +: 18]));
            error_count++;
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    pose_t home;
    logic [3:0] m;
    logic [23:0] step;
    logic [17:0] g;
    logic first_phase;
    int n;
    home = mk_pose(0, 0, 9830, 0, 0, 0);

    // directed rows: register write, restart, typed pose where it is obvious
    rows[0]  = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, home};
    rows[1]  = '{1'b1, REG_MODE, 24'(MODE_X_WAVE), 1'b1, 1'b1, mk_pose(-1966, 0, 9830, 0, 0, 0)};
    rows[2]  = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b0, home};
    rows[3]  = '{1'b1, REG_MODE, 24'(MODE_Y_WAVE), 1'b1, 1'b1, mk_pose(0, -1966, 9830, 0, 0, 0)};
    rows[4]  = '{1'b1, REG_MODE, 24'(MODE_Z_WAVE), 1'b1, 1'b1, mk_pose(0, 0, 9831, 0, 0, 0)};
    rows[5]  = '{1'b1, REG_MODE, 24'(MODE_ROLL), 1'b1, 1'b1, mk_pose(0, 0, 11141, 0, 0, 0)};
    rows[6]  = '{1'b1, REG_MODE, 24'(MODE_PITCH), 1'b1, 1'b1, mk_pose(0, 0, 11141, 0, 0, 0)};
    rows[7]  = '{1'b1, REG_MODE, 24'(MODE_YAW), 1'b0, 1'b0, home};
    // quarter-turn step: yaw walks the four exact points and wraps
    rows[8]  = '{1'b1, REG_PHASE_STEP, 24'd4194304, 1'b1, 1'b1, home};
    rows[9]  = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, mk_pose(0, 0, 9830, 0, 0, 16384)};
    rows[10] = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, home};
    rows[11] = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, mk_pose(0, 0, 9830, 0, 0, -16384)};
    rows[12] = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, home};
    // half-turn step, largest allowed
    rows[13] = '{1'b1, REG_PHASE_STEP, 24'd8388608, 1'b1, 1'b1, home};
    rows[14] = '{1'b1, REG_MODE, 24'(MODE_CIRCLE), 1'b1, 1'b1, mk_pose(1966, 0, 9830, 0, 0, 0)};
    rows[15] = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, mk_pose(-1966, 0, 9830, 0, 0, 0)};
    rows[16] = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, mk_pose(1966, 0, 9830, 0, 0, 0)};
    rows[17] = '{1'b1, REG_MODE, 24'(MODE_CONE), 1'b1, 1'b1, mk_pose(0, 0, 11141, 16384, 0, 0)};
    // zero step: phase stands still at half a turn
    rows[18] = '{1'b1, REG_PHASE_STEP, 24'd0, 1'b0, 1'b1, mk_pose(0, 0, 11141, -16384, 0, 0)};
    rows[19] = '{1'b0, REG_MODE, 24'd0, 1'b0, 1'b1, mk_pose(0, 0, 11141, -16384, 0, 0)};
    // goal pass-through at reset values and extremes
    rows[20] = '{1'b1, REG_MODE, 24'(MODE_GOAL), 1'b0, 1'b1, home};
    rows[21] = '{1'b1, REG_GOAL_X, 24'hFE0000, 1'b0, 1'b1, mk_pose(-131072, 0, 9830, 0, 0, 0)};
    rows[22] = '{1'b1, REG_GOAL_YAW, 24'h01FFFF, 1'b0, 1'b1,
                 mk_pose(-131072, 0, 9830, 0, 0, 131071)};
    // unknown modes give home
    rows[23] = '{1'b1, REG_MODE, 24'd15, 1'b1, 1'b1, home};
    rows[24] = '{1'b1, REG_MODE, 24'd10, 1'b0, 1'b1, home};

    // hold reset at the start, then release it
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].cfg_en) begin
        quiesce();
        write_reg(rows[i].idx, rows[i].val);
        cfg_we <= 1'b0;
      end
      send_tick(rows[i].restart, rows[i].typed, rows[i].want);
    end

    // random phases: new settings while idle, then a run of ticks
    first_phase = 1'b1;
    while (ticks_sent < RANDOM_TICKS + NUM_ROWS) begin
      quiesce();
      if ($urandom_range(0, 3) == 0) begin
        m = 4'($urandom_range(0, 15));
      end else begin
        m = 4'($urandom_range(1, 9));
      end
      write_reg(REG_MODE, {20'($urandom), m});
      if (first_phase || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       step = 24'd0;
          1:       step = 24'd8388608;
          2:       step = 24'($urandom_range(1, 4096));
          default: step = 24'($urandom_range(0, 8388608));
        endcase
        write_reg(REG_PHASE_STEP, step);
      end
      for (int r = REG_GOAL_X; r <= REG_GOAL_YAW; r++) begin
        if (first_phase || $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0:       g = 18'h20000;
            1:       g = 18'h1FFFF;
            default: g = 18'($urandom);
          endcase
          write_reg(3'(r), {6'($urandom), g});
        end
      end
      cfg_we <= 1'b0;
      first_phase = 1'b0;
      n = $urandom_range(20, 90);
      repeat (n) begin
        send_tick($urandom_range(0, 15) == 0, 1'b0, home);
      end
    end

    // drain, then watch for stray poses
    quiesce();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("[sinusoidal_pose_setpoint_generator] OK");
    end else begin
      $display("[sinusoidal_pose_setpoint_generator] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("[sinusoidal_pose_setpoint_generator] ERROR");
    $finish;
  end

endmodule
